// ----- design/kmd_pkg.sv -----
// ----------------------------------------------------------------------------
// Key matrix debouncer package
// Shared types and constants for the per-key timestamp debouncer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kmd_pkg;

  localparam int ROWS      = 8;
  localparam int COLUMNS   = 16;
  localparam int TIME_BITS = 32;
  localparam int KEY_COUNT = ROWS * COLUMNS;
  localparam int KEY_BITS  = $clog2(KEY_COUNT);

  localparam logic [7:0] DEBOUNCE_RESET = 8'd5;

  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_MAP    = 1'b1
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [2:0]  row;
    logic [3:0]  column;
    logic        pressed;
    logic [31:0] now_ms;
    logic [7:0]  map_code;
  } in_word_t;

  typedef struct packed {
    logic [2:0] event_row;
    logic [3:0] event_column;
    logic       event_pressed;
    logic [7:0] scan_code;
    logic       mapped;
  } out_word_t;

  // One entry of the key state memory.
  typedef struct packed {
    logic                 changing;
    logic                 level;
    logic [TIME_BITS-1:0] start;
  } key_state_t;

endpackage

`default_nettype wire

// ----- design/key_matrix_debouncer.sv -----
// ----------------------------------------------------------------------------
// Key matrix debouncer
// Per-key timestamp debounce with a loadable scan code map.
// ----------------------------------------------------------------------------
// Usage:
// Input words arrive on in_word_i under in_valid_i / in_stall_o. A key sample
// (op = OP_SAMPLE) updates the debounce state of one key; a map write
// (op = OP_MAP) loads one scan code and never produces an output word.
// When a changed level has persisted for more than debounce_ms milliseconds
// and is sampled once more, one event word leaves on out_word_o under
// out_valid_o / out_stall_i.
// Throughput is one input word per cycle while in_stall_o is low. Each word
// is a single read-modify-write of one entry of the key state memory (or the
// key map); its registered read is bridged by forwarding of the most recent
// write. An accepted sample is registered in stage 1, and its event then in
// the output register, which stage 1 enters only when the output is free.
// When the receiver stalls, the output register holds its word;
// the stage behind it keeps taking words as long as they produce no event,
// and in_stall_o rises only when an event would have to enter a full output.
// The user writes the debounce time (cfg_valid_i / cfg_ready_o / cfg_data_i)
// only while the block is idle; the block does not enforce this. cfg_ready_o
// is always high. Reset sets debounce_ms to 5 and clears the per-entry
// valid bits, so every key reads as released and stable and every map entry
// reads as unmapped; the block takes words as soon as reset is released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module key_matrix_debouncer
  import kmd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [7:0] cfg_data_i,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);

  // Configuration register.
  logic [7:0] debounce_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      debounce_q <= cfg_data_i;
    end
  end

  // Input side: index of the addressed key and the read of both memories.
  logic                in_accept;
  logic [KEY_BITS-1:0] in_idx;
  logic                in_range;

  assign in_accept = in_valid_i && !in_stall_o;

  always_comb begin
    in_idx   = KEY_BITS'(int'(in_word_i.row) * COLUMNS + int'(in_word_i.column));
    in_range = (int'(in_word_i.row) < ROWS) && (int'(in_word_i.column) < COLUMNS);
  end

  // Stage 1 registers: the word whose memory data has just been read.
  logic     s1_valid_q;
  logic     s1_range_q;
  in_word_t s1_word_q;

  // Key state and key map memories. Entries that were never written are
  // covered by the valid bits below and read as all zero.
  key_state_t state_mem [KEY_COUNT];
  logic [7:0] map_mem   [KEY_COUNT];

  key_state_t state_rdata_q;
  logic [7:0] map_rdata_q;

  logic                state_we;
  key_state_t          state_wdata;
  logic                map_we;
  logic [KEY_BITS-1:0] s1_idx_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      state_rdata_q <= state_mem[in_idx];
      map_rdata_q   <= map_mem[in_idx];
    end
    if (state_we) begin
      state_mem[s1_idx_q] <= state_wdata;
    end
    if (map_we) begin
      map_mem[s1_idx_q] <= s1_word_q.map_code;
    end
  end

  // Per-entry valid bits and a record of the most recent write to each memory,
  // used to forward data that the registered read missed.
  logic [KEY_COUNT-1:0] state_vld_q;
  logic [KEY_COUNT-1:0] map_vld_q;
  logic [KEY_BITS-1:0]  state_last_idx_q;
  key_state_t           state_last_q;
  logic [KEY_BITS-1:0]  map_last_idx_q;
  logic [7:0]           map_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_vld_q <= '0;
      map_vld_q   <= '0;
    end else begin
      if (state_we) begin
        state_vld_q[s1_idx_q] <= 1'b1;
      end
      if (map_we) begin
        map_vld_q[s1_idx_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_we) begin
      state_last_idx_q <= s1_idx_q;
      state_last_q     <= state_wdata;
    end
    if (map_we) begin
      map_last_idx_q <= s1_idx_q;
      map_last_q     <= s1_word_q.map_code;
    end
  end

  // Stage 1 logic.
  logic                 s1_go;
  logic                 out_free;
  logic                 emit;
  key_state_t           cur_state;
  logic [7:0]           cur_code;
  logic [TIME_BITS-1:0] elapsed;

  always_comb begin
    if (!state_vld_q[s1_idx_q]) begin
      cur_state = '0;
    end else if (state_last_idx_q == s1_idx_q) begin
      cur_state = state_last_q;
    end else begin
      cur_state = state_rdata_q;
    end

    if (!map_vld_q[s1_idx_q]) begin
      cur_code = '0;
    end else if (map_last_idx_q == s1_idx_q) begin
      cur_code = map_last_q;
    end else begin
      cur_code = map_rdata_q;
    end

    elapsed = s1_word_q.now_ms[TIME_BITS-1:0] - cur_state.start;

    emit        = 1'b0;
    state_wdata = cur_state;
    state_we    = 1'b0;
    map_we      = 1'b0;

    if (s1_valid_q && s1_range_q) begin
      case (s1_word_q.op)
        OP_MAP: begin
          map_we = 1'b1;
        end
        OP_SAMPLE: begin
          if (cur_state.level != s1_word_q.pressed) begin
            // A new level (or a bounce back) restarts the change.
            state_we             = 1'b1;
            state_wdata.changing = 1'b1;
            state_wdata.level    = s1_word_q.pressed;
            state_wdata.start    = s1_word_q.now_ms[TIME_BITS-1:0];
          end else if (cur_state.changing &&
                       (elapsed > TIME_BITS'(debounce_q))) begin
            state_we             = 1'b1;
            state_wdata.changing = 1'b0;
            emit                 = 1'b1;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end

    out_free = !out_valid_o || !out_stall_i;
    s1_go    = s1_valid_q && (!emit || out_free);

    // Writes happen only when the stage actually advances.
    state_we = state_we && s1_go;
    map_we   = map_we && s1_go;
  end

  assign in_stall_o = s1_valid_q && !s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_word_q  <= in_word_i;
      s1_idx_q   <= in_idx;
      s1_range_q <= in_range;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && emit) begin
      out_word_o.event_row     <= s1_word_q.row;
      out_word_o.event_column  <= s1_word_q.column;
      out_word_o.event_pressed <= s1_word_q.pressed;
      out_word_o.scan_code     <= cur_code;
      out_word_o.mapped        <= (cur_code != 8'd0);
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(state_we && map_we))
    else $error("state and map written by the same word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !(s1_go && emit))
    else $error("event pushed into a stalled output register");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && emit && out_valid_o))
    else $error("input stalled without a blocked event");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_we && !state_wdata.changing) |-> (emit && s1_go))
    else $error("change confirmed without an event");
`endif

endmodule

`default_nettype wire

// ----- test/key_matrix_debouncer_tb.sv -----
// ----------------------------------------------------------------------------
// Key matrix debouncer testbench
// Drives key samples and key map writes into the debouncer, predicts every
// confirmed key event from a private copy of the key state, key map and
// debounce time, and checks each event word field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_matrix_debouncer_tb;
  import kmd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;
  localparam int GAP_PERCENT = 14;
  localparam int MAX_PRINTS  = 30;

  // Predicts the event words of the debouncer and holds the ones not yet seen.
  class debounce_scoreboard;
    logic                 level_q   [KEY_COUNT];
    logic                 changing  [KEY_COUNT];
    logic [TIME_BITS-1:0] start_ms  [KEY_COUNT];
    logic [7:0]           scan_map  [KEY_COUNT];
    logic [7:0]           debounce;
    out_word_t            pending_events [$];
    int                   errors;
    int                   samples;
    int                   map_writes;
    int                   events_checked;

    function new();
      foreach (level_q[k]) begin
        level_q[k]  = 1'b0;
        changing[k] = 1'b0;
        start_ms[k] = '0;
        scan_map[k] = 8'h00;
      end
      debounce       = DEBOUNCE_RESET;
      errors         = 0;
      samples        = 0;
      map_writes     = 0;
      events_checked = 0;
    endfunction

    function string describe(out_word_t e);
      return $sformatf("row %0d col %0d level %0d code %02h mapped %0d",
                       e.event_row, e.event_column, e.event_pressed, e.scan_code, e.mapped);
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTS) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    // Called for every accepted input word; queues the event it causes, if any.
    function void note_word(in_word_t w);
      int                   key;
      logic [TIME_BITS-1:0] elapsed;
      out_word_t            ev;
      if (int'(w.row) >= ROWS || int'(w.column) >= COLUMNS) return;
      key = int'(w.row) * COLUMNS + int'(w.column);
      if (w.op == OP_MAP) begin
        scan_map[key] = w.map_code;
        map_writes++;
        return;
      end
      samples++;
      if (level_q[key] != w.pressed) begin
        level_q[key]  = w.pressed;
        changing[key] = 1'b1;
        start_ms[key] = w.now_ms;
        return;
      end
      if (!changing[key]) return;
      elapsed = w.now_ms - start_ms[key];
      if (elapsed <= {{(TIME_BITS-8){1'b0}}, debounce}) return;
      changing[key]    = 1'b0;
      ev.event_row     = w.row;
      ev.event_column  = w.column;
      ev.event_pressed = w.pressed;
      ev.scan_code     = scan_map[key];
      ev.mapped        = (scan_map[key] != 8'h00);
      pending_events.push_back(ev);
    endfunction

    task check_event(out_word_t got);
      out_word_t want;
      string     bad;
      if (pending_events.size() == 0) begin
        report_mismatch({"event with none expected: ", describe(got)});
        return;
      end
      want = pending_events.pop_front();
      events_checked++;
      bad = "";
      if (got.event_row !== want.event_row) bad = {bad, " event_row"};
      if (got.event_column !== want.event_column) bad = {bad, " event_column"};
      if (got.event_pressed !== want.event_pressed) bad = {bad, " event_pressed"};
      if (got.scan_code !== want.scan_code) bad = {bad, " scan_code"};
      if (got.mapped !== want.mapped) bad = {bad, " mapped"};
      if (bad != "") begin
        report_mismatch($sformatf("fields%s differ: got %s, want %s",
                                  bad, describe(got), describe(want)));
      end
    endtask
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i  = 8'h00;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  in_word_t   in_word_i   = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  out_word_t  out_word_o;

  debounce_scoreboard sb;

  // While calm is set neither side inserts gaps or stalls.
  bit          calm = 1'b0;
  int          words_sent = 0;
  int          settings_used = 0;
  int          cycles = 0;
  logic [31:0] clock_ms = '0;
  logic [7:0]  cur_debounce = DEBOUNCE_RESET;

  key_matrix_debouncer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < GAP_PERCENT);
  endfunction

  // The receiver stalls at random; the decision is made at each falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= take_break();
  end

  // All handshakes are observed at the rising edge, before the block updates.
  // The debounce register is tracked at its write edge so the predictor sees
  // the new value for every word accepted afterwards.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.debounce = cfg_data_i;
      if (in_valid_i && !in_stall_o) sb.note_word(in_word_i);
      if (out_valid_o && !out_stall_i) sb.check_event(out_word_o);
    end
  end

  // Watchdog: a run that hangs or loses events ends here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events outstanding",
               cycles, sb.pending_events.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Presents one word, possibly after a few idle cycles, and holds it until the
  // block takes it. Valid changes only at falling edges, once per edge.
  task automatic send_word(input in_word_t w);
    @(negedge clk_i);
    while (take_break()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic put_sample(input int r, input int c, input bit lvl, input logic [31:0] t);
    in_word_t w;
    w.op       = OP_SAMPLE;
    w.row      = r[2:0];
    w.column   = c[3:0];
    w.pressed  = lvl;
    w.now_ms   = t;
    // The code field is unused by a sample, but it still gets random content.
    w.map_code = 8'($urandom_range(255));
    send_word(w);
  endtask

  task automatic put_map(input int r, input int c, input logic [7:0] code);
    in_word_t w;
    w.op       = OP_MAP;
    w.row      = r[2:0];
    w.column   = c[3:0];
    w.pressed  = 1'($urandom_range(1));
    w.now_ms   = $urandom();
    w.map_code = code;
    send_word(w);
  endtask

  // Any field pattern at all, including samples at unrelated times.
  task automatic put_noise();
    in_word_t w;
    w.op       = op_e'($urandom_range(1));
    w.row      = 3'($urandom_range(7));
    w.column   = 4'($urandom_range(15));
    w.pressed  = 1'($urandom_range(1));
    w.now_ms   = $urandom();
    w.map_code = 8'($urandom_range(255));
    send_word(w);
  endtask

  // Waits until every predicted event has left and the pipeline is empty.
  // Words that cause no event may still be in flight, hence the tail cycles.
  task automatic drain_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_debounce(input logic [7:0] value);
    drain_block();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i  <= 1'b0;
    cur_debounce = value;
    settings_used++;
  endtask

  // A realistic key change on one key: some contact bounce, then a settled
  // level sampled a few times at advancing times, which often outlasts the
  // debounce window and confirms the change.
  task automatic key_episode();
    int r;
    int c;
    bit lvl;
    r   = $urandom_range(ROWS - 1);
    c   = $urandom_range(COLUMNS - 1);
    lvl = 1'($urandom_range(1));
    repeat ($urandom_range(0, 3)) begin
      put_sample(r, c, 1'($urandom_range(1)), clock_ms);
      clock_ms += $urandom_range(0, 2);
    end
    put_sample(r, c, lvl, clock_ms);
    repeat ($urandom_range(1, 3)) begin
      clock_ms += $urandom_range(0, int'(cur_debounce) + 2);
      put_sample(r, c, lvl, clock_ms);
    end
  endtask

  // Mostly key episodes, with map writes and unstructured words mixed in.
  task automatic random_phase(input int target);
    int pick;
    while (words_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        key_episode();
      end else if (pick < 85) begin
        put_map($urandom_range(ROWS - 1), $urandom_range(COLUMNS - 1),
                8'($urandom_range(255)));
      end else begin
        put_noise();
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset debounce time of 5 ms. A press at time 0 is
    // not confirmed at exactly 5 ms elapsed, only at 6.
    put_map(0, 0, 8'hFF);
    put_map(7, 15, 8'h01);
    put_sample(0, 0, 1'b1, 32'd0);
    put_sample(0, 0, 1'b1, 32'd5);
    put_sample(0, 0, 1'b1, 32'd6);
    put_sample(0, 0, 1'b1, 32'd100);
    // The change starts just before the time counter wraps and is confirmed
    // just after it.
    put_sample(7, 15, 1'b1, 32'hFFFF_FFFE);
    put_sample(7, 15, 1'b1, 32'd4);
    // Bounce back: the key returns to its old level before confirming, and the
    // returned level is still reported once it has settled.
    put_sample(3, 9, 1'b1, 32'd200);
    put_sample(3, 9, 1'b0, 32'd202);
    put_sample(3, 9, 1'b0, 32'd210);
    // Release of a key whose map entry was cleared again reports it unmapped.
    put_map(0, 0, 8'h00);
    put_sample(0, 0, 1'b0, 32'd300);
    put_sample(0, 0, 1'b0, 32'hFFFF_FFFF);
    // A matching sample on a stable key does nothing.
    put_map(5, 10, 8'h55);
    put_sample(5, 10, 1'b0, 32'd0);
    put_map(2, 5, 8'hAA);
    put_sample(2, 5, 1'b1, 32'd1000);
    put_sample(2, 5, 1'b1, 32'd1000);
    // With no debounce time any later matching sample confirms.
    write_debounce(8'd0);
    put_sample(2, 5, 1'b1, 32'd1000);
    put_sample(2, 5, 1'b1, 32'd1001);
    // The longest debounce time needs 256 ms to pass.
    write_debounce(8'd255);
    put_sample(2, 5, 1'b0, 32'd5000);
    put_sample(2, 5, 1'b0, 32'd5255);
    put_sample(2, 5, 1'b0, 32'd5256);
    write_debounce(DEBOUNCE_RESET);

    // Random part in four settings; the second runs with no gaps or stalls and
    // the third starts close to the time wrap.
    clock_ms = $urandom();
    random_phase(500);
    write_debounce(8'd0);
    calm = 1'b1;
    random_phase(900);
    calm = 1'b0;
    write_debounce(8'd255);
    clock_ms = 32'hFFFF_FF00;
    random_phase(1300);
    write_debounce(8'($urandom_range(1, 254)));
    random_phase(1875);

    drain_block();
    if (sb.pending_events.size() != 0) begin
      sb.report_mismatch($sformatf("%0d events never arrived", sb.pending_events.size()));
    end

    $display("run: %0d words sent (%0d key samples, %0d map writes) over %0d debounce settings",
             words_sent, sb.samples, sb.map_writes, settings_used);
    $display("run: %0d key events compared, %0d mismatches, %0d cycles",
             sb.events_checked, sb.errors, cycles);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- key_matrix_debouncer.f -----
design/kmd_pkg.sv
design/key_matrix_debouncer.sv
test/key_matrix_debouncer_tb.sv
